// ----- rtl/vfcs_pkg.sv -----
package vfcs_pkg;

	localparam int VOICES_DEF = 8;

	localparam int VOICE_W    = 3;
	localparam int FREQ_W     = 15;
	localparam int SPEED_W    = 8;
	localparam int RATE_W     = 8;
	localparam int DEPTH_W    = 10;
	localparam int KIND_W     = 2;
	localparam int CUT_W      = 16;
	localparam int TICK_W     = 10;
	localparam int STEP_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int DIVIDEND_W = 26;
	localparam int DIVISOR_W  = 11;
	localparam int QUOT_W     = 16;

	localparam logic [CUT_W-1:0]     CUTOFF_MAX = 16'd15000;
	localparam logic [17:0]          LFO_SPAN   = 18'd512;
	localparam logic [DIVISOR_W-1:0] DIV_BASE   = 11'd1010;
	localparam logic [KIND_W-1:0]    FK_BYPASS  = 2'd0;

	// floor(depth / 100) for depth below 1024 as (depth * 41) >> 12
	localparam logic [5:0] DEPTH_RECIP = 6'd41;
	localparam int         DEPTH_SHIFT = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_FREQ  = 3'd0,
		REG_TARGET_FREQ = 3'd1,
		REG_SWEEP_SPEED = 3'd2,
		REG_LFO_RATE    = 3'd3,
		REG_LFO_DEPTH   = 3'd4,
		REG_FILTER_KIND = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_LFO,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CUT_W-1:0]  cutoff;
		logic [TICK_W-1:0] ticks;
		logic              falling;
	} voice_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [STEP_W-1:0] lfo_step(input logic [DEPTH_W-1:0] depth);
		logic [15:0] prod;
		prod = 16'(depth) * 16'(DEPTH_RECIP);
		return prod[15:DEPTH_SHIFT];
	endfunction

	// c * 1000 as (c << 10) - (c << 4) - (c << 3)
	function automatic logic [DIVIDEND_W-1:0] times_1000(input logic [CUT_W-1:0] c);
		logic [DIVIDEND_W-1:0] ce;
		ce = DIVIDEND_W'(c);
		return (ce << 10) - (ce << 4) - (ce << 3);
	endfunction

endpackage

// ----- rtl/vfcs_if.sv -----
interface vfcs_in_if;
	import vfcs_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [VOICE_W-1:0] voice;
	logic               env_active;

	modport source(output valid, kind, voice, env_active, input ready);
	modport sink(input valid, kind, voice, env_active, output ready);
endinterface

interface vfcs_out_if;
	import vfcs_pkg::*;

	logic               valid;
	logic               ready;
	logic [VOICE_W-1:0] voice_out;
	logic [CUT_W-1:0]   cutoff;
	logic [KIND_W-1:0]  mode_out;
	logic               apply_filter;

	modport source(output valid, voice_out, cutoff, mode_out, apply_filter, input ready);
	modport sink(input valid, voice_out, cutoff, mode_out, apply_filter, output ready);
endinterface

// ----- rtl/vfcs_state_mem.sv -----
module vfcs_state_mem #(
	parameter int VOICES = vfcs_pkg::VOICES_DEF,
	localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output vfcs_pkg::voice_state_t rd_data,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  vfcs_pkg::voice_state_t wr_data
);
	import vfcs_pkg::*;

	voice_state_t mem_q [VOICES];
	logic [VOICES-1:0] valid_q;
	voice_state_t rd_mem_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// never written entries read as reset state
	assign rd_data = rd_valid_q ? rd_mem_q : '0;

endmodule

// ----- rtl/vfcs_div.sv -----
module vfcs_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [vfcs_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [vfcs_pkg::DIVISOR_W-1:0]   divisor,
	output vfcs_pkg::div_status_t            status,
	output logic [vfcs_pkg::QUOT_W-1:0]      quotient
);
	import vfcs_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [QUOT_W-1:0]    sh_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W+1:0] diff;
	logic                 ge;

	// one quotient bit per cycle, quotient shifts in behind the dividend bits
	assign diff = {1'b0, rem_q, sh_q[QUOT_W-1]} - {2'b00, dvs_q};
	assign ge = !diff[DIVISOR_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
			sh_q <= dividend[QUOT_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : {rem_q[DIVISOR_W-2:0], sh_q[QUOT_W-1]};
			sh_q <= {sh_q[QUOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient = sh_q;

endmodule

// ----- rtl/voice_filter_cutoff_sweep_lfo.sv -----
// Per-voice filter cutoff sweep with a triangle LFO.
// in_ch carries items (kind, voice, env_active): kind 1 presets the voice's
// cutoff from start_freq, kind 0 is a control tick that advances sweep and
// LFO when env_active is set. Every transfer on in_ch yields one transfer on
// out_ch (voice_out, cutoff, mode_out, apply_filter). Voices at or above
// VOICES are not stored and report cutoff 0.
// The configuration port writes one register per cycle on cfg_we; write it
// only while no item is in flight.
// One item is handled at a time. A downward sweep step runs a bit-serial
// divider, one quotient bit per cycle, between the read and LFO steps; other
// advancing ticks go from the read step to the LFO step, and all remaining
// items go straight from the read step to the done step.
// A finished result waits in the output register while out_ch is stalled; the
// next item is still taken and held until the output register frees.
// Reset clears the configuration and all voice state (cutoff, LFO counter and
// direction) at once through per-voice valid bits.
module voice_filter_cutoff_sweep_lfo #(
	parameter int VOICES = vfcs_pkg::VOICES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vfcs_in_if.sink                         in_ch,
	vfcs_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [vfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vfcs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import vfcs_pkg::*;

	localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [6:0] VOICES_LIM = 7'(VOICES);

	logic [FREQ_W-1:0]  start_q;
	logic [FREQ_W-1:0]  target_q;
	logic [SPEED_W-1:0] speed_q;
	logic [RATE_W-1:0]  rate_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [KIND_W-1:0]  fkind_q;

	state_t state_q, state_d;

	logic               kind_q;
	logic               env_q;
	logic               in_range_q;
	logic [VOICE_W-1:0] voice_q;
	logic [CUT_W-1:0]   c_q;
	logic [TICK_W-1:0]  ticks_q;
	logic               falling_q;

	logic               out_valid_q;
	logic [VOICE_W-1:0] out_voice_q;
	logic [CUT_W-1:0]   out_cutoff_q;
	logic [KIND_W-1:0]  out_mode_q;
	logic               out_apply_q;

	logic         in_xfer;
	logic         in_range;
	logic         rd_en;
	logic         wr_en;
	logic         out_load;
	logic         out_free;
	logic         div_start;
	voice_state_t rd_data;
	voice_state_t wr_data;
	div_status_t  div_st;
	logic [QUOT_W-1:0] quotient;

	logic              adv;
	logic              down_mode;
	logic              need_div;
	logic [CUT_W:0]    up_sum;
	logic [CUT_W-1:0]  c_sweep;
	logic [CUT_W-1:0]  c_read;

	logic              lfo_on;
	logic [STEP_W-1:0] lfo_s;
	logic [CUT_W:0]    lfo_sum;
	logic [CUT_W-1:0]  c_lfo;
	logic [TICK_W-1:0] t_inc;
	logic [17:0]       t_prod;
	logic              flip;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			target_q <= '0;
			speed_q <= '0;
			rate_q <= '0;
			depth_q <= '0;
			fkind_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_FREQ:  start_q <= cfg_data[FREQ_W-1:0];
				REG_TARGET_FREQ: target_q <= cfg_data[FREQ_W-1:0];
				REG_SWEEP_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				REG_LFO_RATE:    rate_q <= cfg_data[RATE_W-1:0];
				REG_LFO_DEPTH:   depth_q <= cfg_data[DEPTH_W-1:0];
				REG_FILTER_KIND: fkind_q <= cfg_data[KIND_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_xfer = in_ch.valid && in_ch.ready;
	assign in_range = {4'b0000, in_ch.voice} < VOICES_LIM;
	assign out_free = !out_valid_q || out_ch.ready;

	vfcs_state_mem #(
		.VOICES(VOICES)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(AW'(in_ch.voice)),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(AW'(voice_q)),
		.wr_data(wr_data)
	);

	// sweep step on the stored cutoff
	assign adv = !kind_q && env_q && in_range_q;
	assign down_mode = (start_q > target_q) && (speed_q != '0);
	assign need_div = adv && down_mode && (rd_data.cutoff > CUT_W'(target_q));
	assign up_sum = (CUT_W + 1)'(rd_data.cutoff) + (CUT_W + 1)'(speed_q);

	always_comb begin
		c_sweep = rd_data.cutoff;
		if (!down_mode && (speed_q != '0) && (rd_data.cutoff < CUT_W'(target_q))) begin
			c_sweep = (up_sum > (CUT_W + 1)'(CUTOFF_MAX)) ? CUTOFF_MAX : up_sum[CUT_W-1:0];
		end
	end

	always_comb begin
		if (!in_range_q) begin
			c_read = '0;
		end else if (kind_q) begin
			c_read = CUT_W'(start_q);
		end else if (adv) begin
			c_read = c_sweep;
		end else begin
			c_read = rd_data.cutoff;
		end
	end

	vfcs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(times_1000(rd_data.cutoff)),
		.divisor(DIV_BASE + DIVISOR_W'(speed_q)),
		.status(div_st),
		.quotient(quotient)
	);

	// lfo step
	assign lfo_on = (rate_q != '0) && (depth_q != '0);
	assign lfo_s = lfo_step(depth_q);
	assign lfo_sum = (CUT_W + 1)'(c_q) + (CUT_W + 1)'(lfo_s);
	assign t_inc = ticks_q + TICK_W'(1);
	assign t_prod = 18'(t_inc) * 18'(rate_q);
	assign flip = t_prod > LFO_SPAN;

	always_comb begin
		c_lfo = c_q;
		if (falling_q) begin
			if (c_q > CUT_W'(lfo_s)) begin
				c_lfo = c_q - CUT_W'(lfo_s);
			end
		end else if (lfo_sum < (CUT_W + 1)'(CUTOFF_MAX)) begin
			c_lfo = lfo_sum[CUT_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (need_div) begin
					state_d = ST_DIV;
				end else if (adv) begin
					state_d = ST_LFO;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_LFO;
				end
			end
			ST_LFO: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		rd_en = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		wr_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				rd_en = in_ch.valid;
			end
			ST_READ: div_start = need_div;
			ST_DONE: begin
				out_load = out_free;
				wr_en = out_free && in_range_q;
			end
			default: ;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= in_ch.kind;
			env_q <= in_ch.env_active;
			in_range_q <= in_range;
			voice_q <= in_ch.voice;
		end
		case (state_q)
			ST_READ: begin
				c_q <= c_read;
				ticks_q <= rd_data.ticks;
				falling_q <= rd_data.falling;
			end
			ST_DIV: begin
				if (div_st.done) begin
					c_q <= quotient;
				end
			end
			ST_LFO: begin
				if (lfo_on) begin
					c_q <= c_lfo;
					ticks_q <= flip ? '0 : t_inc;
					falling_q <= falling_q ^ flip;
				end
			end
			default: ;
		endcase
	end

	assign wr_data.cutoff = c_q;
	assign wr_data.ticks = ticks_q;
	assign wr_data.falling = falling_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_voice_q <= voice_q;
			out_cutoff_q <= c_q;
			out_mode_q <= fkind_q;
			out_apply_q <= in_range_q && (c_q <= CUTOFF_MAX) && (fkind_q != FK_BYPASS);
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.voice_out = out_voice_q;
	assign out_ch.cutoff = out_cutoff_q;
	assign out_ch.mode_out = out_mode_q;
	assign out_ch.apply_filter = out_apply_q;

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_READ)
		else $error("accepted item did not move to the read step");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !div_st.done) |-> div_st.busy)
		else $error("waiting on divider that is not running");

	a_cutoff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !wr_data.cutoff[CUT_W-1])
		else $error("stored cutoff above the start frequency range");

	a_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.apply_filter) |->
			(out_ch.cutoff <= CUTOFF_MAX && out_ch.mode_out != FK_BYPASS))
		else $error("filter update flagged for out of range cutoff or bypass");

endmodule
